// ===== rtl/pkrt_pkg.sv =====
// Shared types and codes for the packed keyed record table.
// Used by pkrt_cell and packed_keyed_record_table_unit; depends on nothing.
`default_nettype none

package pkrt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam int KEY_W    = 30;
    localparam int PAYLOAD_W = 64;
    localparam int AGE_W    = 8;
    localparam int AMOUNT_W = 32;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;

    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 112;

    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [AMOUNT_W-1:0]  amount;
        logic [AGE_W-1:0]     age;
        logic [PAYLOAD_W-1:0] payload;
        logic [KEY_W-1:0]     key;
    } rec_t;

    // Per-cell controls from the table controller.
    typedef struct packed {
        logic valid;
        logic load_new;
        logic shift;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/packed_keyed_record_table_unit.sv =====
// Top level of the packed keyed record table: a chain of record cells with
// a small controller for search, add and remove. Depends on pkrt_pkg, pkrt_cell.
`default_nettype none

// Usage
// The command channel (s_tvalid/s_tready/s_tdata/s_tuser) carries one word per
// command: the operation in s_tuser, the key and the record fields in s_tdata.
// The result channel (m_tvalid/m_tready/m_tdata) returns exactly one word per
// command: a status and, for a successful remove, the removed record.
// The edge that accepts a command loads the command register. Once the result
// register is free, the key is compared against every cell at once, the cells
// are updated (append, or shift the later records down by one) and the result
// register is loaded; m_tvalid and m_tdata come from that register.
// s_tready is high whenever no command is held, so a new command is taken
// only once the held command has updated the cells and the result register,
// since a single command register feeds the single compare-and-update step.
// If the receiver stalls, the held command waits until the result register
// frees; one further result can not overtake it, so nothing is lost.
// After reset the table is empty; no clearing pass is needed because only
// slots below the record count are ever compared or returned.

module packed_keyed_record_table_unit
    import pkrt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [29:0] key, [93:30] payload_in, [101:94] age_in, [133:102] amount_in,
    // [135:134] zero
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] func
    input  wire logic [FUNC_W-1:0]     s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [1:0] status, [65:2] payload_out, [73:66] age_out, [105:74] amount_out,
    // [111:106] zero
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = $clog2(TABLE_DEPTH);

    logic              busy_reg;
    logic [FUNC_W-1:0] func_reg;
    rec_t              cmd_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [OUT_DATA_W-1:0] m_tdata_next;

    rec_t              cell_rec [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] match;
    cell_ctrl_t        cell_ctrl [TABLE_DEPTH];

    logic              accept;
    logic              process;
    logic              found;
    logic [SW-1:0]     slot;
    rec_t              hit_rec;
    logic              is_full;
    logic              do_add;
    logic              do_remove;
    logic [STATUS_W-1:0] status;

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign process  = busy_reg && (!m_tvalid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (process)
            begin
                busy_reg <= 1'b0;
            end
            if (process)
            begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg        <= s_tuser;
            cmd_reg.key     <= s_tdata[KEY_W-1:0];
            cmd_reg.payload <= s_tdata[KEY_W +: PAYLOAD_W];
            cmd_reg.age     <= s_tdata[KEY_W+PAYLOAD_W +: AGE_W];
            cmd_reg.amount  <= s_tdata[KEY_W+PAYLOAD_W+AGE_W +: AMOUNT_W];
        end
        if (process)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    // Keys in the table are unique, so at most one cell matches and the
    // slot and the record can be gathered by plain OR.
    always_comb
    begin
        found   = |match;
        slot    = '0;
        hit_rec = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (match[i])
            begin
                slot    = slot | SW'(i);
                hit_rec = hit_rec | cell_rec[i];
            end
        end
    end

    always_comb
    begin
        is_full    = (count_reg == CW'(TABLE_DEPTH));
        do_add     = 1'b0;
        do_remove  = 1'b0;
        status     = found ? ST_OK : ST_ABSENT;
        count_next = count_reg;
        case (func_reg)
            FUNC_ADD:
            begin
                if (found)
                begin
                    status = ST_DUP;
                end
                else if (is_full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    status     = ST_OK;
                    do_add     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            FUNC_REMOVE:
            begin
                if (found)
                begin
                    do_remove  = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
            end
        endcase

        m_tdata_next = '0;
        m_tdata_next[STATUS_W-1:0] = status;
        if (do_remove)
        begin
            m_tdata_next[STATUS_W +: PAYLOAD_W] = hit_rec.payload;
            m_tdata_next[STATUS_W+PAYLOAD_W +: AGE_W] = hit_rec.age;
            m_tdata_next[STATUS_W+PAYLOAD_W+AGE_W +: AMOUNT_W] = hit_rec.amount;
        end
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        rec_t upper;

        if (i == TABLE_DEPTH - 1)
        begin : g_last
            assign upper = cell_rec[i];
        end
        else
        begin : g_mid
            assign upper = cell_rec[i+1];
        end

        always_comb
        begin
            cell_ctrl[i].valid    = (CW'(i) < count_reg);
            cell_ctrl[i].load_new = process && do_add && (CW'(i) == count_reg);
            cell_ctrl[i].shift    = process && do_remove && (SW'(i) >= slot)
                                    && (CW'(i + 1) < count_reg);
        end

        pkrt_cell u_cell
        (
            .clk       (clk),
            .ctrl      (cell_ctrl[i]),
            .key       (cmd_reg.key),
            .new_rec   (cmd_reg),
            .upper_rec (upper),
            .rec       (cell_rec[i]),
            .match     (match[i])
        );
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ===== rtl/pkrt_cell.sv =====
// One slot of the record table: holds a record, compares it with the
// broadcast key and loads either a new record or its upper neighbour's.
// Depends on pkrt_pkg.
`default_nettype none

module pkrt_cell
    import pkrt_pkg::*;
(
    input  wire logic             clk,
    input  wire cell_ctrl_t       ctrl,
    input  wire logic [KEY_W-1:0] key,
    input  wire rec_t             new_rec,
    input  wire rec_t             upper_rec,
    output rec_t                  rec,
    output logic                  match
);

    rec_t rec_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load_new)
        begin
            rec_reg <= new_rec;
        end
        else if (ctrl.shift)
        begin
            rec_reg <= upper_rec;
        end
    end

    assign rec   = rec_reg;
    assign match = ctrl.valid && (rec_reg.key == key);

endmodule

`default_nettype wire
